// ----- hdl/tsspg_pkg.sv -----
// Package with the word types, codes and controller interface structs of the servo pulse generator.
`timescale 1ns / 1ps

package tsspg_pkg;

  // Command codes carried by an input word.
  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  // Level event codes.
  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_HIGH = 2'd1;
  localparam logic [1:0] LEVEL_LOW  = 2'd2;

  // Status codes.
  localparam logic [2:0] STATUS_TICK      = 3'd0;
  localparam logic [2:0] STATUS_UPDATED   = 3'd1;
  localparam logic [2:0] STATUS_INSERTED  = 3'd2;
  localparam logic [2:0] STATUS_FULL      = 3'd3;
  localparam logic [2:0] STATUS_REMOVED   = 3'd4;
  localparam logic [2:0] STATUS_NOT_FOUND = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_PULSE   = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE   = 2'd1;
  localparam logic [1:0] REG_SLOT_MARGIN = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] MIN_PULSE_RESET   = 16'd1000;
  localparam logic [15:0] MAX_PULSE_RESET   = 16'd5000;
  localparam logic [12:0] SLOT_MARGIN_RESET = 13'd100;

  // Slot period limits.
  localparam logic [15:0] PERIOD_MAX = 16'hFFFF;
  localparam logic [15:0] PERIOD_MIN = 16'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  pin_number;
    logic [15:0] width_ticks;
  } in_word_t;

  typedef struct packed {
    logic [7:0] event_pin;
    logic [1:0] level_event;
    logic [2:0] status;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic tick_rd;
    logic tick_exec;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic scan_done;
  } ctrl_status_t;

endpackage

// ----- hdl/time_slotted_servo_pulse_generator.sv -----
// Top level of the time-slotted servo pulse generator.
//
// Words enter on the in_ channel (valid/stall): a tick, a set of a pin's
// pulse width, or a remove of a pin. Every tick, set and remove word gives
// exactly one result word on the out_ channel; command code 3 is taken and
// dropped. The cfg_ port writes the minimum and maximum pulse width and the
// slot margin while the block is idle; the user must keep to this, as the
// block does not enforce it. A tick passes through ST_TICK_RD, a registered
// read of the slot memory at the current slot, and ST_TICK_EX, which loads
// the result into the output register. A set or remove scans the slot
// table in ST_SCAN one entry a cycle through the memory's read port, then
// commits the outcome in ST_COMMIT once the output register is free.
// A new word is accepted once the previous one has reached the output
// register, so input and output overlap by one word.
// Reset empties every slot, clears the slot timer and the output register,
// and restores the configuration reset values; no clearing pass is needed.
// While the receiver stalls, the output word holds and the block waits in
// ST_TICK_EX or ST_COMMIT with in_stall high until the output register frees.
`timescale 1ns / 1ps

module time_slotted_servo_pulse_generator #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tsspg_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsspg_pkg::out_word_t out_word,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);
  import tsspg_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t sts;

  // Sequencer.
  tsspg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_word.cmd),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Slot table, timer and output register.
  tsspg_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- hdl/tsspg_ctrl.sv -----
// Controller state machine that sequences tick, set and remove words.
`timescale 1ns / 1ps

module tsspg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_cmd,
  output logic                  in_stall,
  input  tsspg_pkg::ctrl_status_t sts,
  output tsspg_pkg::ctrl_cmd_t  cmd
);
  import tsspg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK_RD,
    ST_TICK_EX,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Commands decode from the state, gated by in_valid and the datapath status.
  always_comb begin
    in_stall       = (state_r != ST_IDLE);
    cmd            = '0;
    cmd.accept     = (state_r == ST_IDLE) && in_valid;
    cmd.tick_rd    = (state_r == ST_TICK_RD);
    cmd.tick_exec  = (state_r == ST_TICK_EX) && sts.out_free;
    cmd.scan       = (state_r == ST_SCAN);
    cmd.commit     = (state_r == ST_COMMIT) && sts.out_free;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            state_nxt = ST_TICK_RD;
          end else if (in_cmd == CMD_SET || in_cmd == CMD_REMOVE) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_TICK_RD: state_nxt = ST_TICK_EX;
      ST_TICK_EX: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/tsspg_dp.sv -----
// Datapath with the slot table, slot timer, table scan and output register.
`timescale 1ns / 1ps

module tsspg_dp #(
  parameter int SLOT_COUNT = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tsspg_pkg::in_word_t     in_word,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_stall,
  output tsspg_pkg::out_word_t    out_word,
  input  tsspg_pkg::ctrl_cmd_t    cmd,
  output tsspg_pkg::ctrl_status_t sts
);
  import tsspg_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [7:0]  pin;
    logic [15:0] width;
  } slot_t;

  // Configuration registers.
  logic [15:0] min_r, max_r;
  logic [12:0] margin_r;

  // Slot table: pins and widths in a memory, active flags in flip-flops.
  slot_t                 slot_mem [SLOT_COUNT];
  slot_t                 rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_addr;
  slot_t                 mem_wdata;
  logic [SLOT_COUNT-1:0] valid_r, valid_nxt;

  // Slot timer state.
  logic [IDX_W-1:0] cs_r, cs_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [7:0]       lpin_r, lpin_nxt;
  logic [15:0]      lwidth_r, lwidth_nxt;
  logic             pulse_r, pulse_nxt;

  // Accepted word, with the set width already clamped.
  logic [1:0]  cmd_r;
  logic [7:0]  pin_r;
  logic [15:0] width_r;
  logic [15:0] clamp_hi, clamp_lo, clamp_w;

  // Scan state.
  logic [IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             issued_all_r, issued_all_nxt;
  logic             eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic             empty_r, empty_nxt;
  logic [IDX_W-1:0] ins_idx_r, ins_idx_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      load_out;

  // Period and tick arithmetic.
  logic [16:0] period_sum, t_inc;
  logic [15:0] period;

  // Width clamp: maximum first, then minimum, and never zero.
  always_comb begin
    clamp_hi = (in_word.width_ticks > max_r) ? max_r : in_word.width_ticks;
    clamp_lo = (clamp_hi < min_r) ? min_r : clamp_hi;
    clamp_w  = (clamp_lo == 16'd0) ? 16'd1 : clamp_lo;
  end

  // Slot period saturates into its legal range.
  always_comb begin
    period_sum = {1'b0, max_r} + {4'b0, margin_r};
    if (period_sum > {1'b0, PERIOD_MAX}) begin
      period = PERIOD_MAX;
    end else if (period_sum < {1'b0, PERIOD_MIN}) begin
      period = PERIOD_MIN;
    end else begin
      period = period_sum[15:0];
    end
    t_inc = {1'b0, tick_r} + 17'd1;
  end

  assign rd_addr = cmd.tick_rd ? cs_r : scan_idx_r;

  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.scan_done = eval_vld_r && (eval_idx_r == LAST_IDX);

  // Next-state logic for the timer, scan, table and output.
  always_comb begin
    valid_nxt      = valid_r;
    cs_nxt         = cs_r;
    tick_nxt       = tick_r;
    lpin_nxt       = lpin_r;
    lwidth_nxt     = lwidth_r;
    pulse_nxt      = pulse_r;
    scan_idx_nxt   = scan_idx_r;
    issued_all_nxt = issued_all_r;
    eval_vld_nxt   = 1'b0;
    eval_idx_nxt   = eval_idx_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    empty_nxt      = empty_r;
    ins_idx_nxt    = ins_idx_r;
    mem_we         = 1'b0;
    mem_addr       = match_idx_r;
    mem_wdata      = '{pin: pin_r, width: width_r};
    load_out       = 1'b0;
    out_word_nxt   = out_word_r;

    // A new word restarts the scan.
    if (cmd.accept) begin
      scan_idx_nxt   = '0;
      issued_all_nxt = 1'b0;
      found_nxt      = 1'b0;
      empty_nxt      = 1'b0;
    end

    // Scan issues one slot read a cycle and checks the previous read.
    if (cmd.scan) begin
      if (!issued_all_r) begin
        eval_vld_nxt = 1'b1;
        eval_idx_nxt = scan_idx_r;
        if (scan_idx_r == LAST_IDX) begin
          issued_all_nxt = 1'b1;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      if (eval_vld_r) begin
        if (!valid_r[eval_idx_r]) begin
          empty_nxt   = 1'b1;
          ins_idx_nxt = eval_idx_r;
        end else if (rd_data_r.pin == pin_r && !found_r) begin
          found_nxt     = 1'b1;
          match_idx_nxt = eval_idx_r;
        end
      end
    end

    // Tick: start, end or hold the current slot's pulse, and advance the slot timer.
    if (cmd.tick_exec) begin
      load_out     = 1'b1;
      out_word_nxt = '{event_pin: 8'd0, level_event: LEVEL_NONE, status: STATUS_TICK};
      if (tick_r == 16'd0) begin
        if (valid_r[cs_r]) begin
          lpin_nxt     = rd_data_r.pin;
          lwidth_nxt   = rd_data_r.width;
          pulse_nxt    = 1'b1;
          out_word_nxt = '{event_pin: rd_data_r.pin, level_event: LEVEL_HIGH,
                           status: STATUS_TICK};
        end
      end else if (pulse_r && (tick_r >= lwidth_r || t_inc >= {1'b0, period})) begin
        pulse_nxt    = 1'b0;
        out_word_nxt = '{event_pin: lpin_r, level_event: LEVEL_LOW, status: STATUS_TICK};
      end
      if (t_inc >= {1'b0, period}) begin
        tick_nxt = 16'd0;
        cs_nxt   = (cs_r == LAST_IDX) ? '0 : cs_r + 1'b1;
      end else begin
        tick_nxt = t_inc[15:0];
      end
    end

    // Commit the outcome of a set or remove scan.
    if (cmd.commit) begin
      load_out     = 1'b1;
      out_word_nxt = '{event_pin: pin_r, level_event: LEVEL_NONE, status: STATUS_FULL};
      if (cmd_r == CMD_SET) begin
        if (found_r) begin
          mem_we              = 1'b1;
          mem_addr            = match_idx_r;
          out_word_nxt.status = STATUS_UPDATED;
        end else if (empty_r) begin
          mem_we              = 1'b1;
          mem_addr            = ins_idx_r;
          valid_nxt[ins_idx_r] = 1'b1;
          out_word_nxt.status = STATUS_INSERTED;
        end
      end else begin
        if (found_r) begin
          valid_nxt[match_idx_r] = 1'b0;
          out_word_nxt.status    = STATUS_REMOVED;
          if (pulse_r && cs_r == match_idx_r) begin
            pulse_nxt                = 1'b0;
            out_word_nxt.level_event = LEVEL_LOW;
          end
        end else begin
          out_word_nxt.status = STATUS_NOT_FOUND;
        end
      end
    end

    // Output register holds until the receiver takes the word.
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) out_valid_nxt = 1'b1;
  end

  // Control and timer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cs_r         <= '0;
      tick_r       <= 16'd0;
      lpin_r       <= 8'd0;
      lwidth_r     <= 16'd0;
      pulse_r      <= 1'b0;
      scan_idx_r   <= '0;
      issued_all_r <= 1'b0;
      eval_vld_r   <= 1'b0;
      eval_idx_r   <= '0;
      found_r      <= 1'b0;
      match_idx_r  <= '0;
      empty_r      <= 1'b0;
      ins_idx_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      cs_r         <= cs_nxt;
      tick_r       <= tick_nxt;
      lpin_r       <= lpin_nxt;
      lwidth_r     <= lwidth_nxt;
      pulse_r      <= pulse_nxt;
      scan_idx_r   <= scan_idx_nxt;
      issued_all_r <= issued_all_nxt;
      eval_vld_r   <= eval_vld_nxt;
      eval_idx_r   <= eval_idx_nxt;
      found_r      <= found_nxt;
      match_idx_r  <= match_idx_nxt;
      empty_r      <= empty_nxt;
      ins_idx_r    <= ins_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= MIN_PULSE_RESET;
      max_r    <= MAX_PULSE_RESET;
      margin_r <= SLOT_MARGIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_PULSE:   min_r    <= cfg_wdata;
        REG_MAX_PULSE:   max_r    <= cfg_wdata;
        REG_SLOT_MARGIN: margin_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  // Payload registers: accepted word and output word.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r   <= in_word.cmd;
      pin_r   <= in_word.pin_number;
      width_r <= clamp_w;
    end
    out_word_r <= out_word_nxt;
  end

  // Slot memory with one write port and a registered read port. The read
  // data holds while a tick waits for the output register to free.
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_addr] <= mem_wdata;
    if (cmd.tick_rd || cmd.scan) rd_data_r <= slot_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ----- hdl/tsspg_checker.sv -----
// Port-level checker for the servo pulse generator and its bind statement.
`timescale 1ns / 1ps

module tsspg_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input tsspg_pkg::out_word_t out_word
);
  import tsspg_pkg::*;

  // A stalled result word stays and holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Only a tick drives a pin high.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.level_event == LEVEL_HIGH |-> out_word.status == STATUS_TICK)
    else $error("drive high on a non-tick result");

  // A pin is driven low only by a tick or a removal.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.level_event == LEVEL_LOW
      |-> out_word.status == STATUS_TICK || out_word.status == STATUS_REMOVED)
    else $error("drive low on a set or failed remove");

  // A tick without a level change names pin zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == STATUS_TICK && out_word.level_event == LEVEL_NONE
      |-> out_word.event_pin == 8'd0)
    else $error("tick without level change names a pin");

endmodule

bind time_slotted_servo_pulse_generator tsspg_checker u_tsspg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
